// ===== design/sll_pkg.sv =====
// Shared types, step codes and the control program of the linked list engine.
`default_nettype none
package sll_pkg;

	// Operation codes carried on the opcode port.
	localparam logic [1:0] OP_INS = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_RD  = 2'd2;

	// Steps of the control program.
	typedef enum logic [4:0] {
		S_CLR  = 5'd0,
		S_IDLE = 5'd1,
		S_DISP = 5'd2,
		S_INS0 = 5'd3,
		S_INS1 = 5'd4,
		S_INS2 = 5'd5,
		S_INS3 = 5'd6,
		S_INS4 = 5'd7,
		S_INS5 = 5'd8,
		S_DEL0 = 5'd9,
		S_DEL1 = 5'd10,
		S_DEL2 = 5'd11,
		S_DEL3 = 5'd12,
		S_DEL4 = 5'd13,
		S_DEL5 = 5'd14,
		S_RD0  = 5'd15,
		S_RD1  = 5'd16,
		S_RD2  = 5'd17,
		S_FIN  = 5'd18
	} step_t;

	// How the next step is chosen.
	typedef enum logic [1:0] {
		NX_NEXT = 2'd0,
		NX_JUMP = 2'd1,
		NX_HOLD = 2'd2,
		NX_DISP = 2'd3
	} nx_t;

	// Conditions that a jump can test.
	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_IN_ACC   = 3'd1,
		C_CNT_ZERO = 3'd2,
		C_OUT_FREE = 3'd3,
		C_NOSLOT   = 3'd4,
		C_CLR_LAST = 3'd5
	} cond_t;

	// Link memory read address sources.
	typedef enum logic [2:0] {
		RA_K     = 3'd0,
		RA_HEAD  = 3'd1,
		RA_ZERO  = 3'd2,
		RA_RDATA = 3'd3,
		RA_WALK  = 3'd4
	} ra_t;

	// Link memory write address sources.
	typedef enum logic [1:0] {
		WA_CLR  = 2'd0,
		WA_ZERO = 2'd1,
		WA_K    = 2'd2,
		WA_J    = 2'd3
	} wa_t;

	// Link memory write data sources.
	typedef enum logic [1:0] {
		WD_CLR   = 2'd0,
		WD_RDATA = 2'd1,
		WD_J     = 2'd2
	} wd_t;

	// Step counter loads.
	typedef enum logic [1:0] {
		CNT_KEEP = 2'd0,
		CNT_INC  = 2'd1,
		CNT_POSM1 = 2'd2,
		CNT_POS  = 2'd3
	} cnt_op_t;

	// Element count updates.
	typedef enum logic [1:0] {
		LEN_KEEP = 2'd0,
		LEN_INC  = 2'd1,
		LEN_DEC  = 2'd2
	} len_op_t;

	// One control word of the program.
	typedef struct packed {
		nx_t     nx;
		cond_t   cond;
		step_t   target;
		ra_t     ra;
		logic    lwe;
		wa_t     wa;
		wd_t     wd;
		logic    dwe;
		cnt_op_t cnt_op;
		len_op_t len_op;
		logic    k_head;
		logic    j_ld;
		logic    walk;
		logic    clr_res;
		logic    set_ok;
		logic    set_rd;
		logic    accept;
		logic    fin;
	} ctl_t;

	// Status flags returned by the datapath.
	typedef struct packed {
		logic in_acc;
		logic cnt_zero;
		logic out_free;
		logic noslot;
		logic clr_last;
		logic disp_ins;
		logic disp_del;
		logic disp_rd;
	} stat_t;

	// The control program itself.
	function automatic ctl_t rom_word(step_t s);
		ctl_t c;
		c = '0;
		c.ra = RA_K;
		c.nx = NX_NEXT;
		c.cond = C_ALWAYS;
		c.target = S_IDLE;
		case (s)
			S_CLR: begin
				c.lwe = 1'b1;
				c.wa = WA_CLR;
				c.wd = WD_CLR;
				c.cnt_op = CNT_INC;
				c.nx = NX_HOLD;
				c.cond = C_CLR_LAST;
				c.target = S_IDLE;
			end
			S_IDLE: begin
				c.accept = 1'b1;
				c.nx = NX_HOLD;
				c.cond = C_IN_ACC;
				c.target = S_DISP;
			end
			S_DISP: begin
				c.clr_res = 1'b1;
				c.nx = NX_DISP;
			end
			S_INS0: begin
				c.ra = RA_ZERO;
				c.cnt_op = CNT_POSM1;
			end
			S_INS1: begin
				c.j_ld = 1'b1;
				c.ra = RA_RDATA;
				c.nx = NX_JUMP;
				c.cond = C_NOSLOT;
				c.target = S_FIN;
			end
			S_INS2: begin
				c.lwe = 1'b1;
				c.wa = WA_ZERO;
				c.wd = WD_RDATA;
				c.dwe = 1'b1;
				c.k_head = 1'b1;
				c.ra = RA_HEAD;
			end
			S_INS3: begin
				c.walk = 1'b1;
				c.ra = RA_WALK;
				c.nx = NX_HOLD;
				c.cond = C_CNT_ZERO;
				c.target = S_INS4;
			end
			S_INS4: begin
				c.lwe = 1'b1;
				c.wa = WA_J;
				c.wd = WD_RDATA;
			end
			S_INS5: begin
				c.lwe = 1'b1;
				c.wa = WA_K;
				c.wd = WD_J;
				c.len_op = LEN_INC;
				c.set_ok = 1'b1;
				c.nx = NX_JUMP;
				c.target = S_FIN;
			end
			S_DEL0: begin
				c.cnt_op = CNT_POSM1;
				c.k_head = 1'b1;
				c.ra = RA_HEAD;
			end
			S_DEL1: begin
				c.walk = 1'b1;
				c.ra = RA_WALK;
				c.nx = NX_HOLD;
				c.cond = C_CNT_ZERO;
				c.target = S_DEL2;
			end
			S_DEL2: begin
				c.j_ld = 1'b1;
				c.ra = RA_RDATA;
				c.nx = NX_JUMP;
				c.cond = C_NOSLOT;
				c.target = S_FIN;
			end
			S_DEL3: begin
				c.lwe = 1'b1;
				c.wa = WA_K;
				c.wd = WD_RDATA;
				c.ra = RA_ZERO;
			end
			S_DEL4: begin
				c.lwe = 1'b1;
				c.wa = WA_J;
				c.wd = WD_RDATA;
			end
			S_DEL5: begin
				c.lwe = 1'b1;
				c.wa = WA_ZERO;
				c.wd = WD_J;
				c.len_op = LEN_DEC;
				c.set_ok = 1'b1;
				c.nx = NX_JUMP;
				c.target = S_FIN;
			end
			S_RD0: begin
				c.cnt_op = CNT_POS;
				c.k_head = 1'b1;
				c.ra = RA_HEAD;
			end
			S_RD1: begin
				c.walk = 1'b1;
				c.ra = RA_WALK;
				c.nx = NX_HOLD;
				c.cond = C_CNT_ZERO;
				c.target = S_RD2;
			end
			S_RD2: begin
				c.set_ok = 1'b1;
				c.set_rd = 1'b1;
			end
			S_FIN: begin
				c.fin = 1'b1;
				c.nx = NX_HOLD;
				c.cond = C_OUT_FREE;
				c.target = S_IDLE;
			end
			default: begin
				c.nx = NX_JUMP;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/sll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/sll_seq.sv =====
// Step counter and program table that sequence the linked list datapath.
`default_nettype none
module sll_seq
	import sll_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctl_t       ctl
);

	step_t upc_q;
	step_t upc_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_CLR;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		ctl = rom_word(upc_q);
		case (ctl.cond)
			C_ALWAYS:   take = 1'b1;
			C_IN_ACC:   take = stat.in_acc;
			C_CNT_ZERO: take = stat.cnt_zero;
			C_OUT_FREE: take = stat.out_free;
			C_NOSLOT:   take = stat.noslot;
			C_CLR_LAST: take = stat.clr_last;
			default:    take = 1'b0;
		endcase
		case (ctl.nx)
			NX_NEXT: upc_d = step_t'(upc_q + 5'd1);
			NX_JUMP: upc_d = take ? ctl.target : step_t'(upc_q + 5'd1);
			NX_HOLD: upc_d = take ? ctl.target : upc_q;
			NX_DISP: begin
				if (stat.disp_ins) begin
					upc_d = S_INS0;
				end else if (stat.disp_del) begin
					upc_d = S_DEL0;
				end else if (stat.disp_rd) begin
					upc_d = S_RD0;
				end else begin
					upc_d = S_FIN;
				end
			end
			default: upc_d = S_IDLE;
		endcase
	end

	// The clearing pass only ever leaves toward the idle step.
	a_clr_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == S_CLR) |=> (upc_q == S_CLR || upc_q == S_IDLE))
		else $error("clearing pass left to an unexpected step");

	// A finished result waits while the output register is still occupied.
	a_fin_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == S_FIN && !stat.out_free) |=> (upc_q == S_FIN))
		else $error("result step left while output register busy");

	// A walk that still has links to follow stays in its walk step.
	a_walk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((upc_q == S_INS3 || upc_q == S_DEL1 || upc_q == S_RD1) && !stat.cnt_zero)
		|=> (upc_q == $past(upc_q)))
		else $error("walk ended before its step count ran out");

endmodule
`default_nettype wire

// ===== design/sll_dp.sv =====
// Datapath of the linked list engine: link and element memories, cursors, counters, result.
`default_nettype none
module sll_dp
	import sll_pkg::*;
#(
	parameter int SLOTS = 1024,
	parameter int DATA_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_t        ctl,
	output stat_t            stat,
	input  wire logic        in_valid,
	input  wire logic [1:0]  opcode,
	input  wire logic [9:0]  position,
	input  wire logic signed [31:0] value,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic             ok,
	output logic signed [31:0] read_value,
	output logic [9:0]       length
);

	localparam int LW   = $clog2(SLOTS);
	localparam int CW   = (LW > 10) ? LW : 10;
	localparam int PW   = CW + 1;
	localparam int VW   = (DATA_BITS < 32) ? DATA_BITS : 32;
	localparam logic [LW-1:0] HEAD = LW'(SLOTS - 1);
	localparam logic [LW-1:0] CNT_MAX = LW'(SLOTS - 2);

	logic [1:0]           op_q;
	logic [9:0]           pos_q;
	logic [DATA_BITS-1:0] val_q;
	logic [LW-1:0]        k_q;
	logic [LW-1:0]        j_q;
	logic [CW-1:0]        cnt_q;
	logic [LW-1:0]        count_q;
	logic                 ok_q;
	logic [31:0]          rd_q;

	logic [LW-1:0]        l_raddr;
	logic [LW-1:0]        l_waddr;
	logic [LW-1:0]        l_wdata;
	logic [LW-1:0]        l_rdata;
	logic [DATA_BITS-1:0] d_rdata;
	logic                 cnt_zero;
	logic                 in_acc;
	logic                 out_free;
	logic                 pos_in;
	logic                 pos_ins;

	assign cnt_zero = (cnt_q == '0);
	assign in_acc   = in_valid && ctl.accept;
	assign out_free = !out_valid || !out_stall;
	assign pos_in   = (pos_q != 10'd0) && (PW'(pos_q) <= PW'(count_q));
	assign pos_ins  = (pos_q != 10'd0) && (PW'(pos_q) <= PW'(count_q) + PW'(1));

	always_comb begin
		stat.in_acc   = in_acc;
		stat.cnt_zero = cnt_zero;
		stat.out_free = out_free;
		stat.noslot   = (l_rdata == '0) || (l_rdata == HEAD);
		stat.clr_last = (cnt_q == CW'(SLOTS - 1));
		stat.disp_ins = (op_q == OP_INS) && pos_ins;
		stat.disp_del = (op_q == OP_DEL) && pos_in;
		stat.disp_rd  = (op_q == OP_RD) && pos_in;
	end

	always_comb begin
		case (ctl.ra)
			RA_K:     l_raddr = k_q;
			RA_HEAD:  l_raddr = HEAD;
			RA_ZERO:  l_raddr = '0;
			RA_RDATA: l_raddr = l_rdata;
			RA_WALK:  l_raddr = cnt_zero ? k_q : l_rdata;
			default:  l_raddr = k_q;
		endcase
		case (ctl.wa)
			WA_CLR:  l_waddr = cnt_q[LW-1:0];
			WA_ZERO: l_waddr = '0;
			WA_K:    l_waddr = k_q;
			WA_J:    l_waddr = j_q;
			default: l_waddr = k_q;
		endcase
		case (ctl.wd)
			WD_CLR:   l_wdata = (cnt_q >= CW'(SLOTS - 2)) ? '0 : LW'(cnt_q + CW'(1));
			WD_RDATA: l_wdata = l_rdata;
			WD_J:     l_wdata = j_q;
			default:  l_wdata = l_rdata;
		endcase
	end

	sll_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_link (
		.clk  (clk),
		.we   (ctl.lwe),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	sll_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(SLOTS)
	) u_elem (
		.clk  (clk),
		.we   (ctl.dwe),
		.waddr(j_q),
		.wdata(val_q),
		.raddr(k_q),
		.rdata(d_rdata)
	);

	// Captured operation and the payload-only cursors.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= DATA_BITS'(value[VW-1:0]);
		end
		if (ctl.k_head) begin
			k_q <= HEAD;
		end else if (ctl.walk && !cnt_zero) begin
			k_q <= l_rdata;
		end
		if (ctl.j_ld) begin
			j_q <= l_rdata;
		end
		if (ctl.clr_res) begin
			rd_q <= '0;
		end else if (ctl.set_rd) begin
			rd_q <= 32'(d_rdata[VW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			count_q    <= '0;
			ok_q       <= 1'b0;
			out_valid  <= 1'b0;
			ok         <= 1'b0;
			read_value <= '0;
			length     <= '0;
		end else begin
			case (ctl.cnt_op)
				CNT_INC:   cnt_q <= cnt_q + CW'(1);
				CNT_POSM1: cnt_q <= CW'(pos_q) - CW'(1);
				CNT_POS:   cnt_q <= CW'(pos_q);
				default: begin
					if (ctl.walk && !cnt_zero) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			endcase
			case (ctl.len_op)
				LEN_INC: count_q <= count_q + LW'(1);
				LEN_DEC: count_q <= count_q - LW'(1);
				default: count_q <= count_q;
			endcase
			if (ctl.clr_res) begin
				ok_q <= 1'b0;
			end else if (ctl.set_ok) begin
				ok_q <= 1'b1;
			end
			if (ctl.fin && out_free) begin
				out_valid  <= 1'b1;
				ok         <= ok_q;
				read_value <= rd_q;
				length     <= 10'(count_q);
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// The list never holds more than the slot count minus the two head slots.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("element count beyond capacity");

	// An element is only ever stored into a real data slot.
	a_store_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dwe |-> (j_q != '0 && j_q != HEAD))
		else $error("element written to a head slot");

	// Linking a slot after itself would close a loop in the data chain.
	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.lwe && ctl.wa == WA_K && ctl.wd == WD_J) |-> (k_q != j_q))
		else $error("slot linked to itself");

endmodule
`default_nettype wire

// ===== design/static_linked_list_engine.sv =====
// Top level of the linked list engine: sequencer plus datapath.
`default_nettype none
// A linked list kept in a fixed array of SLOTS slots, driven by a small
// microprogram. Slot 0 heads the chain of free slots and the last slot heads
// the chain of data slots, so the list holds at most SLOTS-2 words. Each input
// word carries an opcode (insert, delete or read), a one-based position and,
// for an insert, the value to store; each one produces exactly one result word
// with a success flag, the read value (zero unless a read succeeded) and the
// list length after the operation. Operations run one at a time. Reaching a
// position means following the links from the data head, one link memory read
// per cycle, and that walk sets the latency. After reset the engine initializes
// the link memory and stalls its input until that pass is done. A finished
// result sits in an output register, so the next word is taken while the
// previous result still waits for the consumer.
module static_linked_list_engine
	import sll_pkg::*;
#(
	parameter int SLOTS = 1024,
	parameter int DATA_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [9:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    ok,
	output logic signed [31:0]      read_value,
	output logic [9:0]              length
);

	ctl_t  ctl;
	stat_t stat;

	// The program only opens the input in its idle step.
	assign in_stall = !ctl.accept;

	sll_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctl   (ctl)
	);

	sll_dp #(
		.SLOTS    (SLOTS),
		.DATA_BITS(DATA_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.position  (position),
		.value     (value),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.ok        (ok),
		.read_value(read_value),
		.length    (length)
	);

endmodule
`default_nettype wire

// ===== sim/list_result_check.sv =====
// Result checker for the linked list engine: tracks the list, predicts each result word, compares.
`timescale 1ns / 1ps
module list_result_check
	import sll_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [9:0]  position,
	input  wire logic [31:0] value,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        ok,
	input  wire logic [31:0] read_value,
	input  wire logic [9:0]  length,
	output int               fail_count,
	output int               pending,
	output logic [9:0]       list_len
);

	localparam int SLOTS = 1024;
	localparam logic [9:0] DATA_HEAD = 10'(SLOTS - 1);
	localparam logic [9:0] FREE_HEAD = 10'd0;

	typedef struct packed {
		logic        ok;
		logic [31:0] rd;
		logic [9:0]  len;
	} list_result_t;

	logic [9:0]   link_mem [SLOTS];
	logic [31:0]  value_mem [SLOTS];
	logic [9:0]   elem_cnt;
	list_result_t expected_results [$];

	assign list_len = elem_cnt;

	// Follows the chain from the data head for the given number of links.
	function automatic logic [9:0] walk_links(int steps);
		logic [9:0] k;
		k = DATA_HEAD;
		for (int s = 0; s < steps; s++)
			k = link_mem[k];
		return k;
	endfunction

	// Applies one word to the tracked list and returns the result it must produce.
	function automatic list_result_t predict_word(logic [1:0] op, logic [9:0] pos,
		logic [31:0] val);
		list_result_t res;
		logic [9:0] j;
		logic [9:0] k;
		res = '0;
		case (op)
			OP_INS: begin
				if (pos >= 1 && int'(pos) <= int'(elem_cnt) + 1) begin
					j = link_mem[FREE_HEAD];
					if (j != FREE_HEAD && j != DATA_HEAD) begin
						link_mem[FREE_HEAD] = link_mem[j];
						value_mem[j] = val;
						k = walk_links(int'(pos) - 1);
						link_mem[j] = link_mem[k];
						link_mem[k] = j;
						elem_cnt = elem_cnt + 10'd1;
						res.ok = 1'b1;
					end
				end
			end
			OP_DEL: begin
				if (pos >= 1 && pos <= elem_cnt) begin
					k = walk_links(int'(pos) - 1);
					j = link_mem[k];
					if (j != FREE_HEAD && j != DATA_HEAD) begin
						link_mem[k] = link_mem[j];
						link_mem[j] = link_mem[FREE_HEAD];
						link_mem[FREE_HEAD] = j;
						elem_cnt = elem_cnt - 10'd1;
						res.ok = 1'b1;
					end
				end
			end
			OP_RD: begin
				if (pos >= 1 && pos <= elem_cnt) begin
					res.rd = value_mem[walk_links(int'(pos))];
					res.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.len = elem_cnt;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				link_mem[i] = 10'(i + 1);
				value_mem[i] = '0;
			end
			link_mem[SLOTS - 2] = FREE_HEAD;
			link_mem[SLOTS - 1] = FREE_HEAD;
			elem_cnt = '0;
			expected_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// A result never belongs to the word taken at the same edge, so check first.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result word: ok=%0d value=%0d length=%0d",
							$time, ok, $signed(read_value), length);
				end else begin
					want = expected_results.pop_front();
					if (ok !== want.ok || read_value !== want.rd || length !== want.len) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t result mismatch: expected ok=%0d value=%0d length=%0d, %s",
								$time, want.ok, $signed(want.rd), want.len,
								$sformatf("got ok=%0d value=%0d length=%0d",
									ok, $signed(read_value), length));
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_word(opcode, position, value));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/static_linked_list_engine_tb.sv =====
// Testbench top for the linked list engine: stimulus, clock, reset and the final verdict.
`timescale 1ns / 1ps
module static_linked_list_engine_tb;
	import sll_pkg::*;

	// Opcode 3 has no meaning; the engine must reject it and leave the list alone.
	localparam logic [1:0] OP_NONE = 2'd3;
	// Length that the calm stretch grows the list to with front inserts.
	localparam int CALM_LEN = 120;
	localparam int RANDOM_WORDS = 300;
	// Size the random part keeps pulling back towards, so walks stay short.
	localparam int SOFT_CAP = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  opcode = OP_INS;
	logic [9:0]  position = '0;
	logic [31:0] value = '0;
	logic        out_stall = 1'b0;
	// While set, neither side inserts bubbles or back pressure.
	logic        calm = 1'b0;

	wire logic        in_stall;
	wire logic        out_valid;
	wire logic        ok;
	wire logic [31:0] read_value;
	wire logic [9:0]  length;

	int         fail_count;
	int         pending;
	logic [9:0] list_len;

	static_linked_list_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.read_value (read_value),
		.length     (length)
	);

	// The checker sees both channels, keeps its own copy of the list and
	// reports the number of failures, the words still owed and the list length
	// that the stimulus uses to aim positions.
	list_result_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.read_value (read_value),
		.length     (length),
		.fail_count (fail_count),
		.pending    (pending),
		.list_len   (list_len)
	);

	always #5 clk = ~clk;

	// The consumer holds off results in roughly a fifth of the cycles, except
	// during the calm stretch.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99, 0) < 22);
	end

	// Hard stop. The slowest legal run would need every word to walk the full
	// list, plus stalls; this leaves plenty of room.
	initial begin
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	// Presents one word at the current falling edge, possibly after a few idle
	// cycles, holds it until the engine takes it, and returns at the next
	// falling edge so that the caller sees the checker's updated length.
	task automatic send_word(input logic [1:0] op, input logic [9:0] pos,
		input logic [31:0] val);
		while (!calm && $urandom_range(99, 0) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		opcode <= op;
		position <= pos;
		value <= val;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		int n;
		int r;
		logic [1:0] op;
		logic [9:0] pos;

		// Reset is held from time zero and released on a falling edge. The
		// engine then clears its link memory and stalls the input meanwhile,
		// which the handshake absorbs.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on an empty list: reads and deletes beyond the end,
		// position zero, insert past the end, then a small list built from the
		// extreme values at the front, the back and the middle.
		send_word(OP_RD, 10'd1, 32'h0000_0000);
		send_word(OP_DEL, 10'd1, 32'hFFFF_FFFF);
		send_word(OP_INS, 10'd0, 32'h1234_5678);
		send_word(OP_INS, 10'd2, 32'h1234_5678);
		send_word(OP_INS, 10'd1, 32'h7FFF_FFFF);
		send_word(OP_INS, 10'd2, 32'h8000_0000);
		send_word(OP_INS, 10'd1, 32'h0000_0000);
		send_word(OP_INS, 10'd4, 32'hFFFF_FFFF);
		send_word(OP_RD, 10'd1, 32'h0000_0000);
		send_word(OP_RD, 10'd2, 32'h0000_0000);
		send_word(OP_RD, 10'd3, 32'h0000_0000);
		send_word(OP_RD, 10'd4, 32'h0000_0000);
		send_word(OP_RD, 10'd5, 32'h0000_0000);
		send_word(OP_RD, 10'd0, 32'h0000_0000);
		send_word(OP_RD, 10'd1023, 32'h0000_0000);
		send_word(OP_NONE, 10'd1, 32'hFFFF_FFFF);
		send_word(OP_DEL, 10'd0, 32'h0000_0000);
		send_word(OP_DEL, 10'd1023, 32'h0000_0000);
		send_word(OP_DEL, 10'd4, 32'h0000_0000);
		send_word(OP_DEL, 10'd2, 32'h0000_0000);
		send_word(OP_RD, 10'd1, 32'h0000_0000);
		send_word(OP_RD, 10'd2, 32'h0000_0000);

		// Grow the list with inserts at the front, which keeps every walk
		// short. This is the stretch with no idling on either side.
		calm = 1'b1;
		while (int'(list_len) < CALM_LEN)
			send_word(OP_INS, 10'd1, $urandom());

		// Then work at the far end of the list, where the walks are longest:
		// insert past the end, read the last word and one beyond it, delete the
		// last word, append a new one, read it back and delete past the end.
		n = int'(list_len);
		send_word(OP_INS, 10'(n + 2), $urandom());
		send_word(OP_RD, 10'(n), 32'h0000_0000);
		send_word(OP_RD, 10'(n + 1), 32'h0000_0000);
		send_word(OP_DEL, 10'(n), 32'h0000_0000);
		send_word(OP_INS, 10'(n), $urandom());
		send_word(OP_RD, 10'(n), 32'h0000_0000);
		send_word(OP_DEL, 10'(n + 1), 32'h0000_0000);
		calm = 1'b0;

		// Random part. Legal positions dominate so that most words actually move
		// the list; a few are rejected on purpose. Inserts outweigh deletes below
		// the soft cap and lose above it, so the length hovers near the cap.
		for (int w = 0; w < RANDOM_WORDS; w++) begin
			n = int'(list_len);
			r = $urandom_range(99, 0);
			if (r < 6) begin
				case ($urandom_range(2, 0))
					0: begin
						op = OP_NONE;
						pos = 10'($urandom_range(1023, 0));
					end
					1: begin
						op = 2'($urandom_range(3, 0));
						pos = '0;
					end
					default: begin
						op = 2'($urandom_range(2, 0));
						pos = 10'($urandom_range(1023, n + 2));
					end
				endcase
			end else if (r < (n > SOFT_CAP ? 30 : 52)) begin
				op = OP_INS;
				pos = 10'($urandom_range(n + 1, 1));
			end else if (r < 76) begin
				op = OP_DEL;
				pos = 10'($urandom_range(n > 0 ? n : 1, 1));
			end else begin
				op = OP_RD;
				pos = 10'($urandom_range(n > 0 ? n : 1, 1));
			end
			send_word(op, pos, $urandom());
		end
		in_valid <= 1'b0;

		// Let every owed result arrive, then give the engine time to show any
		// stray result word before the verdict.
		while (pending != 0)
			@(negedge clk);
		repeat (1100) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
